@@ rtl/cpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // Frame store size in bytes and the address width that follows from it.
  localparam int FRAME_BYTES = 1048576;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  // Byte offsets are computed as signed 32-bit values.
  localparam int OFF_W = 32;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_PIXEL_DEPTH = 3'd0,
    CFG_RASTER_OP   = 3'd1,
    CFG_CLIP_LEFT   = 3'd2,
    CFG_CLIP_TOP    = 3'd3,
    CFG_CLIP_RIGHT  = 3'd4,
    CFG_CLIP_BOTTOM = 3'd5,
    CFG_LINE_PITCH  = 3'd6
  } cfg_idx_t;

  // Raster operation codes.
  typedef enum logic [1:0] {
    ROP_SET = 2'd0,
    ROP_XOR = 2'd1,
    ROP_OR  = 2'd2,
    ROP_AND = 2'd3
  } rop_t;

  // Pixel depth codes; the unused code behaves as 24bpp.
  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2
  } depth_t;

  // Live configuration shared by the front and back parts.
  typedef struct packed {
    logic [1:0]         pixel_depth;
    logic [1:0]         raster_op;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic signed [15:0] clip_right;
    logic signed [15:0] clip_bottom;
    logic [13:0]        line_pitch;
  } cpr_cfg_t;

  // A classified access as it travels from the front to the back.
  typedef struct packed {
    logic              wr;
    logic              clipped;
    logic              oos;
    logic [1:0]        nbytes;
    logic [ADDR_W-1:0] addr;
    logic [23:0]       src;
  } cpr_item_t;

endpackage

`default_nettype wire

@@ rtl/cpr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpr_front import cpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cpr_cfg_t    cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_wr,
  input  wire logic [15:0] in_x,
  input  wire logic [15:0] in_y,
  input  wire logic [23:0] in_color,
  output logic             push_valid,
  input  wire logic        push_ready,
  output cpr_item_t        push_data
);

  logic signed [15:0] x_s;
  logic signed [15:0] y_s;
  logic signed [14:0] pitch_s;
  logic signed [17:0] x18;
  logic signed [30:0] prod_next;
  logic signed [17:0] xs_next;
  logic [1:0]         nbytes_next;
  logic [23:0]        src_next;
  logic               clip_next;
  logic               advance;

  // Stage one registers.
  logic               s1_valid;
  logic               s1_wr;
  logic               s1_clipped;
  logic signed [30:0] s1_prod;
  logic signed [17:0] s1_xs;
  logic [1:0]         s1_nbytes;
  logic [23:0]        s1_src;

  // Stage two: offset and store range check.
  logic signed [OFF_W-1:0] off;
  logic signed [OFF_W-1:0] limit;
  logic                    oos;

  assign x_s     = $signed(in_x);
  assign y_s     = $signed(in_y);
  assign pitch_s = $signed({1'b0, cfg.line_pitch});
  assign x18     = {{2{x_s[15]}}, x_s};

  // Clip test against the inclusive rectangle.
  assign clip_next = (x_s < cfg.clip_left) || (x_s > cfg.clip_right) ||
                     (y_s < cfg.clip_top)  || (y_s > cfg.clip_bottom);

  // Row term on the multiplier; column term by shift and add.
  assign prod_next = y_s * pitch_s;

  always_comb begin
    unique case (cfg.pixel_depth)
      DEPTH_8: begin
        nbytes_next = 2'd1;
        xs_next     = x18;
      end
      DEPTH_16: begin
        nbytes_next = 2'd2;
        xs_next     = x18 <<< 1;
      end
      default: begin
        nbytes_next = 2'd3;
        xs_next     = x18 + (x18 <<< 1);
      end
    endcase
  end

  // 24bpp writes go to the store high byte first.
  assign src_next = (nbytes_next == 2'd3) ?
                    {in_color[7:0], in_color[15:8], in_color[23:16]} :
                    {8'h00, in_color[15:0]};

  assign advance  = !s1_valid || push_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_wr      <= in_wr;
      s1_clipped <= clip_next;
      s1_prod    <= prod_next;
      s1_xs      <= xs_next;
      s1_nbytes  <= nbytes_next;
      s1_src     <= src_next;
    end
  end

  assign off   = {{(OFF_W - 31){s1_prod[30]}}, s1_prod} +
                 {{(OFF_W - 18){s1_xs[17]}}, s1_xs};
  assign limit = $signed(OFF_W'(FRAME_BYTES)) - $signed(OFF_W'(s1_nbytes));
  assign oos   = !s1_clipped && ((off < 0) || (off > limit));

  assign push_valid        = s1_valid;
  assign push_data.wr      = s1_wr;
  assign push_data.clipped = s1_clipped;
  assign push_data.oos     = oos;
  assign push_data.nbytes  = s1_nbytes;
  assign push_data.addr    = off[ADDR_W-1:0];
  assign push_data.src     = s1_src;

endmodule

`default_nettype wire

@@ rtl/cpr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpr_queue import cpr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire cpr_item_t push_data,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output cpr_item_t      pop_data
);

  cpr_item_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cpr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpr_back import cpr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cpr_cfg_t  cfg,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire cpr_item_t pop_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [23:0]    out_color,
  output logic [1:0]     out_flags
);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  state_t            state;
  cpr_item_t         cur;
  logic [1:0]        cnt;
  logic [1:0]        pidx;
  logic [23:0]       old;

  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rdata;

  logic              out_free;
  logic              skip;
  logic              pop;
  logic              last;
  logic              emit;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        src_byte;
  logic [7:0]        wr_byte;
  logic [23:0]       old_next;

  function automatic logic [7:0] combine(input logic [1:0] op, input logic [7:0] a,
                                         input logic [7:0] b);
    logic [7:0] r;
    unique case (op)
      ROP_SET: r = b;
      ROP_XOR: r = a ^ b;
      ROP_OR:  r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign skip      = pop_data.clipped || pop_data.oos;
  assign pop_ready = (state == S_IDLE) && (!skip || out_free);
  assign pop       = pop_ready && pop_valid;
  assign last      = (cnt == cur.nbytes);

  // A result word is loaded for a skipped access or on the last byte of any other one.
  assign emit = (state == S_IDLE) ? (pop && skip) : (last && out_free);

  // Byte reads run one ahead of the combine and write-back of the previous byte.
  assign rd_en   = (pop && !skip) || ((state == S_BUSY) && !last);
  assign rd_addr = (state == S_IDLE) ? pop_data.addr : cur.addr + ADDR_W'(cnt);
  assign wr_en   = (state == S_BUSY) && cur.wr;
  assign wr_addr = cur.addr + ADDR_W'(pidx);

  always_comb begin
    unique case (pidx)
      2'd0:    src_byte = cur.src[7:0];
      2'd1:    src_byte = cur.src[15:8];
      default: src_byte = cur.src[23:16];
    endcase
  end

  assign wr_byte = combine(cfg.raster_op, rdata, src_byte);

  // Old pixel is assembled little-endian for every depth.
  always_comb begin
    old_next = old;
    unique case (pidx)
      2'd0:    old_next[7:0]   = rdata;
      2'd1:    old_next[15:8]  = rdata;
      default: old_next[23:16] = rdata;
    endcase
  end

  // Frame store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (skip) begin
              out_color <= '0;
              out_flags <= {pop_data.oos, pop_data.clipped};
            end else begin
              cur   <= pop_data;
              cnt   <= 2'd1;
              pidx  <= 2'd0;
              old   <= '0;
              state <= S_BUSY;
            end
          end
        end
        S_BUSY: begin
          if (!last) begin
            old  <= old_next;
            pidx <= cnt;
            cnt  <= cnt + 2'd1;
          end else if (out_free) begin
            out_color <= old_next;
            out_flags <= 2'b00;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/clipped_pixel_raster_op_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                          Word
// -------   -------------------------------  ---------------------------------
// s_axis    tvalid tready tdata tuser        pixel access (cmd, x, y, color)
// m_axis    tvalid tready tdata tuser        old pixel and status flags
// cfg       valid ready index data           one configuration register
//
// In the back end a pixel access reads the frame store one byte at a time
// through its single read port, and a write combines and writes back each byte
// through its single write port; clipped and out-of-store words skip the store.
// The front end's registered stage feeds the two-entry queue before the back end.
// Reset clears control state and the configuration; the frame store is not
// cleared. Either side may stall at any time without loss.
module clipped_pixel_raster_op_core import cpr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // pos_x[15:0], pos_y[31:16], color[55:32]
  input  wire logic [0:0]  s_axis_tuser,  // cmd[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // old_color[23:0]
  output logic [1:0]       m_axis_tuser,  // clipped[0], out_of_store[1]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cpr_cfg_t  cfg;
  logic      q_push_valid;
  logic      q_push_ready;
  cpr_item_t q_push_data;
  logic      q_pop_valid;
  logic      q_pop_ready;
  cpr_item_t q_pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_depth <= DEPTH_8;
      cfg.raster_op   <= ROP_SET;
      cfg.clip_left   <= 16'sd0;
      cfg.clip_top    <= 16'sd0;
      cfg.clip_right  <= 16'sd32767;
      cfg.clip_bottom <= 16'sd32767;
      cfg.line_pitch  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIXEL_DEPTH: cfg.pixel_depth <= cfg_data[1:0];
        CFG_RASTER_OP:   cfg.raster_op   <= cfg_data[1:0];
        CFG_CLIP_LEFT:   cfg.clip_left   <= $signed(cfg_data);
        CFG_CLIP_TOP:    cfg.clip_top    <= $signed(cfg_data);
        CFG_CLIP_RIGHT:  cfg.clip_right  <= $signed(cfg_data);
        CFG_CLIP_BOTTOM: cfg.clip_bottom <= $signed(cfg_data);
        CFG_LINE_PITCH:  cfg.line_pitch  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  cpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_wr      (s_axis_tuser[0]),
    .in_x       (s_axis_tdata[15:0]),
    .in_y       (s_axis_tdata[31:16]),
    .in_color   (s_axis_tdata[55:32]),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  cpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  cpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_color (m_axis_tdata),
    .out_flags (m_axis_tuser)
  );

endmodule

`default_nettype wire
